// ----- sv/rrp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and constants of the request parser: counter widths, byte
// codes, result kinds and the result record.
// ----------------------------------------------------------------------------
package rrp_pkg;

   localparam int CountBits = 20;
   localparam int IdxBits   = 20;
   localparam int AccBits   = CountBits + 4;

   localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};
   localparam logic [AccBits-1:0]   Ten    = AccBits'(10);

   localparam logic [7:0] ChCr   = 8'h0d;
   localparam logic [7:0] ChZero = 8'h30;
   localparam logic [7:0] ChNine = 8'h39;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_EMPTY_ARG = 2'd1,
      KIND_EMPTY_CMD = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0]         data_byte;
      logic [IdxBits-1:0] arg_index;
      kind_type           kind;
      logic               last_of_arg;
      logic               last_of_command;
   } rsp_type;

endpackage
`default_nettype wire

// ----- sv/resp_request_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// resp_request_parser
// Byte-serial parser for requests framed as an array of bulk strings.
// ----------------------------------------------------------------------------
// Takes one request byte per clock cycle while req_stall is low. Each accepted
// byte updates the parse state in the same cycle and any result it causes is
// registered into the output register or, while that is held, into the skid
// register. The result side is thus a two-deep buffer, so input keeps flowing
// while one result waits; req_stall rises only once both are full and comes
// straight from a register. Payload bytes carry their argument index and
// last-of-argument / last-of-command flags; an empty argument or an empty
// command yields one marker result. Counts saturate at 2^20 - 1.
// ----------------------------------------------------------------------------
module resp_request_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic [7:0]                  req_in_byte,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic [7:0]                  rsp_data_byte,
   output      logic [rrp_pkg::IdxBits-1:0] rsp_arg_index,
   output      logic [1:0]                  rsp_kind,
   output      logic                        rsp_last_of_arg,
   output      logic                        rsp_last_of_command
);

   typedef enum logic [3:0] {
      PH_ARR_TYPE = 4'd0,
      PH_ARR_NUM  = 4'd1,
      PH_ARR_LF   = 4'd2,
      PH_STR_TYPE = 4'd3,
      PH_STR_NUM  = 4'd4,
      PH_STR_LF   = 4'd5,
      PH_DATA     = 4'd6,
      PH_TAIL_CR  = 4'd7,
      PH_TAIL_LF  = 4'd8
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [rrp_pkg::CountBits-1:0]   accum_ff, accum_in;
   logic [rrp_pkg::CountBits-1:0]   args_left_ff, args_left_in;
   logic [rrp_pkg::CountBits-1:0]   cur_arg_ff, cur_arg_in;
   logic [rrp_pkg::CountBits-1:0]   bytes_left_ff, bytes_left_in;

   logic                            out_valid_ff;
   rrp_pkg::rsp_type                out_ff;
   logic                            skid_valid_ff;
   rrp_pkg::rsp_type                skid_ff;

   logic                            accept;
   logic                            out_take;
   logic                            res_valid;
   rrp_pkg::rsp_type                res;

   logic                            is_digit;
   logic [rrp_pkg::AccBits-1:0]     acc_sum;
   logic [rrp_pkg::CountBits-1:0]   acc_folded;
   logic [rrp_pkg::CountBits-1:0]   bytes_dec;
   logic [rrp_pkg::IdxBits-1:0]     cur_idx;

   assign accept   = req_valid && !skid_valid_ff;
   assign out_take = out_valid_ff && !rsp_stall;

   assign is_digit   = (req_in_byte >= rrp_pkg::ChZero) && (req_in_byte <= rrp_pkg::ChNine);
   assign acc_sum    = rrp_pkg::AccBits'(accum_ff) * rrp_pkg::Ten
                     + rrp_pkg::AccBits'(4'(req_in_byte - rrp_pkg::ChZero));
   assign acc_folded = (acc_sum > rrp_pkg::AccBits'(rrp_pkg::CntMax)) ? rrp_pkg::CntMax
                     : acc_sum[rrp_pkg::CountBits-1:0];
   assign bytes_dec  = bytes_left_ff - rrp_pkg::CountBits'(1);
   assign cur_idx    = rrp_pkg::IdxBits'(cur_arg_ff);

   always_comb begin
      phase_in      = phase_ff;
      accum_in      = accum_ff;
      args_left_in  = args_left_ff;
      cur_arg_in    = cur_arg_ff;
      bytes_left_in = bytes_left_ff;
      res_valid     = 1'b0;
      res.data_byte       = '0;
      res.arg_index       = cur_idx;
      res.kind            = rrp_pkg::KIND_DATA;
      res.last_of_arg     = 1'b0;
      res.last_of_command = 1'b0;
      case (phase_ff)
         PH_ARR_TYPE: begin
            accum_in = '0;
            phase_in = PH_ARR_NUM;
         end
         PH_ARR_NUM: begin
            if (req_in_byte == rrp_pkg::ChCr) begin
               phase_in = PH_ARR_LF;
            end else if (is_digit) begin
               accum_in = acc_folded;
            end
         end
         PH_ARR_LF: begin
            args_left_in = accum_ff;
            cur_arg_in   = '0;
            if (accum_ff == '0) begin
               res_valid           = 1'b1;
               res.arg_index       = '0;
               res.kind            = rrp_pkg::KIND_EMPTY_CMD;
               res.last_of_command = 1'b1;
               phase_in            = PH_ARR_TYPE;
            end else begin
               phase_in = PH_STR_TYPE;
            end
         end
         PH_STR_TYPE: begin
            accum_in = '0;
            phase_in = PH_STR_NUM;
         end
         PH_STR_NUM: begin
            if (req_in_byte == rrp_pkg::ChCr) begin
               phase_in = PH_STR_LF;
            end else if (is_digit) begin
               accum_in = acc_folded;
            end
         end
         PH_STR_LF: begin
            bytes_left_in = accum_ff;
            if (accum_ff == '0) begin
               res_valid           = 1'b1;
               res.kind            = rrp_pkg::KIND_EMPTY_ARG;
               res.last_of_arg     = 1'b1;
               res.last_of_command = (args_left_ff == rrp_pkg::CountBits'(1));
               phase_in            = PH_TAIL_CR;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            bytes_left_in       = bytes_dec;
            res_valid           = 1'b1;
            res.data_byte       = req_in_byte;
            res.last_of_arg     = (bytes_dec == '0);
            res.last_of_command = (bytes_dec == '0)
                                && (args_left_ff == rrp_pkg::CountBits'(1));
            if (bytes_dec == '0) begin
               phase_in = PH_TAIL_CR;
            end
         end
         PH_TAIL_CR: begin
            phase_in = PH_TAIL_LF;
         end
         PH_TAIL_LF: begin
            args_left_in = args_left_ff - rrp_pkg::CountBits'(1);
            cur_arg_in   = cur_arg_ff + rrp_pkg::CountBits'(1);
            phase_in     = (args_left_ff == rrp_pkg::CountBits'(1)) ? PH_ARR_TYPE
                                                                   : PH_STR_TYPE;
         end
         default: begin
            phase_in      = PH_ARR_TYPE;
            accum_in      = '0;
            args_left_in  = '0;
            cur_arg_in    = '0;
            bytes_left_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ARR_TYPE;
         accum_ff      <= '0;
         args_left_ff  <= '0;
         cur_arg_ff    <= '0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         accum_ff      <= accum_in;
         args_left_ff  <= args_left_in;
         cur_arg_ff    <= cur_arg_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   // output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept && res_valid;
         end
      end else if (accept && res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_take) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end
      if (out_valid_ff && !out_take && !skid_valid_ff) begin
         skid_ff <= res;
      end
   end

   assign req_stall           = skid_valid_ff;
   assign rsp_valid           = out_valid_ff;
   assign rsp_data_byte       = out_ff.data_byte;
   assign rsp_arg_index       = out_ff.arg_index;
   assign rsp_kind            = out_ff.kind;
   assign rsp_last_of_arg     = out_ff.last_of_arg;
   assign rsp_last_of_command = out_ff.last_of_command;

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a transfer while output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid register filled while output was free");

   a_empty_cmd_flags: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == rrp_pkg::KIND_EMPTY_CMD)
      |-> (out_ff.last_of_command && !out_ff.last_of_arg && out_ff.data_byte == '0))
      else $error("empty-command marker with wrong flags");

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bytes_left_ff != '0))
      else $error("payload phase entered with no bytes left");

endmodule
`default_nettype wire
